### design/read_pair_alignment_classifier_defines.svh
// Assertion helpers shared by the classifier RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef READ_PAIR_ALIGNMENT_CLASSIFIER_DEFINES_SVH
`define READ_PAIR_ALIGNMENT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define RPAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rpac_pkg.sv
`timescale 1ns / 1ps

package rpac_pkg;

  localparam int QUERY_LENGTH_BITS = 16;
  localparam int FRACTION_BITS     = 16;

  localparam int FRAC_W   = FRACTION_BITS + 1;
  localparam int QUAL_W   = 8;
  localparam int KIND_W   = 4;
  localparam int OP_LEN_W = 28;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = QUERY_LENGTH_BITS + FRAC_W;
  localparam int LIMIT_W  = PROD_W - FRACTION_BITS;
  localparam int CLIP_CMP_W = (OP_LEN_W > LIMIT_W) ? OP_LEN_W : LIMIT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (FRAC_W > QUAL_W) ? FRAC_W : QUAL_W;

  // 0.2 and 0.1 rounded to the nearest fraction step
  localparam logic [FRAC_W-1:0] CLIP_TOL_RST =
    FRAC_W'(((64'd1 << FRACTION_BITS) * 2 + 5) / 10);
  localparam logic [FRAC_W-1:0] MM_RATE_RST =
    FRAC_W'(((64'd1 << FRACTION_BITS) + 5) / 10);
  localparam logic [QUAL_W-1:0] MIN_MAPQ_RST = '0;

  localparam logic [KIND_W-1:0] OP_INSERT   = 4'd1;
  localparam logic [KIND_W-1:0] OP_DELETE   = 4'd2;
  localparam logic [KIND_W-1:0] OP_SOFT     = 4'd4;
  localparam logic [KIND_W-1:0] OP_MISMATCH = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_TOL = 2'd0,
    REG_MM_RATE  = 2'd1,
    REG_MIN_MAPQ = 2'd2
  } rpac_reg_e;

  typedef enum logic [1:0] {
    ST_ANCHOR = 2'd0,
    ST_ORPHAN = 2'd1,
    ST_SOFT   = 2'd2,
    ST_POOR   = 2'd3
  } rpac_status_e;

  typedef enum logic [2:0] {
    CLS_NORMAL = 3'd0,
    CLS_ORPHAN = 3'd1,
    CLS_SOFT   = 3'd2,
    CLS_POOR   = 3'd3,
    CLS_OTHER  = 3'd4
  } rpac_class_e;

  typedef struct packed {
    logic                         read_unmapped;
    logic [QUERY_LENGTH_BITS-1:0] query_length;
    logic [QUAL_W-1:0]            map_quality;
    logic [KIND_W-1:0]            op_kind;
    logic [OP_LEN_W-1:0]          op_length;
    logic                         last_of_mate;
  } rpac_in_t;

  typedef struct packed {
    logic [2:0] pair_class;
    logic       mates_swapped;
    logic [1:0] first_mate_status;
    logic [1:0] second_mate_status;
  } rpac_out_t;

  typedef struct packed {
    logic [FRAC_W-1:0] clip_tolerance;
    logic [FRAC_W-1:0] mismatch_rate_limit;
    logic [QUAL_W-1:0] min_map_quality;
  } rpac_cfg_t;

  // One operation after the front register: limits are already scaled.
  typedef struct packed {
    logic                read_unmapped;
    logic                qlen_zero;
    logic [QUAL_W-1:0]   map_quality;
    logic [KIND_W-1:0]   op_kind;
    logic [OP_LEN_W-1:0] op_length;
    logic                last_of_mate;
    logic [LIMIT_W-1:0]  clip_limit;
    logic [LIMIT_W-1:0]  mm_limit;
  } rpac_item_t;

  // Pair class once the anchor mate is known to be in front.
  function automatic rpac_class_e class_of(rpac_status_e second);
    rpac_class_e c;
    case (second)
      ST_ANCHOR: c = CLS_NORMAL;
      ST_ORPHAN: c = CLS_ORPHAN;
      ST_SOFT:   c = CLS_SOFT;
      default:   c = CLS_POOR;
    endcase
    return c;
  endfunction

endpackage

### design/rpac_cfg_regs.sv
`timescale 1ns / 1ps

module rpac_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpac_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rpac_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output rpac_pkg::rpac_cfg_t                 cfg_o
);
  import rpac_pkg::*;

  rpac_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CLIP_TOL: cfg_d.clip_tolerance      = cfg_wdata_i[FRAC_W-1:0];
        REG_MM_RATE:  cfg_d.mismatch_rate_limit = cfg_wdata_i[FRAC_W-1:0];
        REG_MIN_MAPQ: cfg_d.min_map_quality     = cfg_wdata_i[QUAL_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_tolerance      <= CLIP_TOL_RST;
      cfg_q.mismatch_rate_limit <= MM_RATE_RST;
      cfg_q.min_map_quality     <= MIN_MAPQ_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/rpac_ingress.sv
`timescale 1ns / 1ps

module rpac_ingress (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpac_pkg::rpac_cfg_t   cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rpac_pkg::rpac_in_t    in_data_i,
  output logic                  item_valid_o,
  output rpac_pkg::rpac_item_t  item_o,
  input  logic                  item_take_i
);
  import rpac_pkg::*;

  logic              valid_q, valid_d;
  rpac_item_t        item_q, item_d;
  logic              in_xfer;
  logic [PROD_W-1:0] clip_prod;
  logic [PROD_W-1:0] mm_prod;

  assign in_stall_o = valid_q && !item_take_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Scale both fractions by this op's query length on the way in.
  assign clip_prod = PROD_W'(cfg_i.clip_tolerance) * PROD_W'(in_data_i.query_length);
  assign mm_prod   = PROD_W'(cfg_i.mismatch_rate_limit) * PROD_W'(in_data_i.query_length);

  always_comb begin
    item_d.read_unmapped = in_data_i.read_unmapped;
    item_d.qlen_zero     = (in_data_i.query_length == '0);
    item_d.map_quality   = in_data_i.map_quality;
    item_d.op_kind       = in_data_i.op_kind;
    item_d.op_length     = in_data_i.op_length;
    item_d.last_of_mate  = in_data_i.last_of_mate;
    item_d.clip_limit    = clip_prod[PROD_W-1:FRACTION_BITS];
    item_d.mm_limit      = mm_prod[PROD_W-1:FRACTION_BITS];
  end

  always_comb begin
    valid_d = valid_q;
    if (in_xfer) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### design/rpac_classifier.sv
`timescale 1ns / 1ps
`include "read_pair_alignment_classifier_defines.svh"

module rpac_classifier (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rpac_pkg::rpac_cfg_t   cfg_i,
  input  logic                  item_valid_i,
  input  rpac_pkg::rpac_item_t  item_i,
  output logic                  item_take_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rpac_pkg::rpac_out_t   out_data_o
);
  import rpac_pkg::*;

  logic             on_second_q, on_second_d;
  logic             at_first_q, at_first_d;
  logic             head_clip_q, head_clip_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  rpac_status_e     mate1_q, mate1_d;
  logic             out_valid_q, out_valid_d;
  rpac_out_t        out_q, out_d;

  logic             long_clip;
  logic             counts;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_new;
  logic             clipped;
  logic             within_rate;
  rpac_status_e     status;
  logic             emits;
  logic             swapped;
  rpac_class_e      cls;

  assign long_clip = (item_i.op_kind == OP_SOFT) &&
                     (CLIP_CMP_W'(item_i.op_length) >= CLIP_CMP_W'(item_i.clip_limit));
  assign counts = (item_i.op_kind == OP_INSERT) || (item_i.op_kind == OP_DELETE) ||
                  (item_i.op_kind == OP_MISMATCH);

  // saturating mismatch accumulate
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(item_i.op_length);
  always_comb begin
    sum_new = sum_q;
    if (counts) begin
      sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end
  end

  assign clipped     = (at_first_q ? long_clip : head_clip_q) || long_clip;
  assign within_rate = (sum_new <= SUM_W'(item_i.mm_limit));

  always_comb begin
    if (item_i.read_unmapped) begin
      status = ST_ORPHAN;
    end else if (clipped) begin
      status = ST_SOFT;
    end else if (item_i.qlen_zero) begin
      status = ST_POOR;
    end else if ((item_i.map_quality >= cfg_i.min_map_quality) && within_rate) begin
      status = ST_ANCHOR;
    end else begin
      status = ST_POOR;
    end
  end

  assign emits       = item_i.last_of_mate && on_second_q;
  assign item_take_o = item_valid_i && (!emits || !out_valid_q || !out_stall_i);

  assign swapped = (mate1_q != ST_ANCHOR) && (status == ST_ANCHOR);
  always_comb begin
    if (swapped) begin
      cls = class_of(mate1_q);
    end else if (mate1_q != ST_ANCHOR) begin
      cls = CLS_OTHER;
    end else begin
      cls = class_of(status);
    end
  end

  always_comb begin
    on_second_d = on_second_q;
    at_first_d  = at_first_q;
    head_clip_d = head_clip_q;
    sum_d       = sum_q;
    mate1_d     = mate1_q;
    if (item_take_o) begin
      if (item_i.last_of_mate) begin
        at_first_d  = 1'b1;
        head_clip_d = 1'b0;
        sum_d       = '0;
        on_second_d = !on_second_q;
        if (!on_second_q) begin
          mate1_d = status;
        end
      end else begin
        at_first_d = 1'b0;
        sum_d      = sum_new;
        if (at_first_q) begin
          head_clip_d = long_clip;
        end
      end
    end
  end

  always_comb begin
    out_d.pair_class         = cls;
    out_d.mates_swapped      = swapped;
    out_d.first_mate_status  = mate1_q;
    out_d.second_mate_status = status;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o && emits) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_second_q <= 1'b0;
      at_first_q  <= 1'b1;
      head_clip_q <= 1'b0;
      sum_q       <= '0;
      mate1_q     <= ST_ANCHOR;
      out_valid_q <= 1'b0;
    end else begin
      on_second_q <= on_second_d;
      at_first_q  <= at_first_d;
      head_clip_q <= head_clip_d;
      sum_q       <= sum_d;
      mate1_q     <= mate1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && emits) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `RPAC_ASSERT_IMP(a_no_overwrite, out_valid_q && out_stall_i, !(item_take_o && emits), "result overwritten while stalled")
  `RPAC_ASSERT_NXT(a_result_loaded, item_take_o && emits, out_valid_q, "result not loaded")
  `RPAC_ASSERT_NXT(a_mate_toggle, item_take_o && item_i.last_of_mate, on_second_q != $past(on_second_q), "mate pointer did not advance")
  `RPAC_ASSERT_IMP(a_fresh_mate, at_first_q, (sum_q == '0) && !head_clip_q, "mate state not cleared")
  `RPAC_ASSERT_IMP(a_swap_anchor, out_valid_q && out_q.mates_swapped, (out_q.second_mate_status == ST_ANCHOR) && (out_q.first_mate_status != ST_ANCHOR), "swap without anchor")

endmodule

### design/read_pair_alignment_classifier.sv
`timescale 1ns / 1ps
// A result is registered once mate two's last op has passed the front register
//   and been taken by the classifier stage.
// One CIGAR op per cycle while in_stall_o is low; limits for the op are scaled by its query
//   length in the multipliers ahead of the front register.
// Reset (rst_ni, async, active low): both stages empty, mate tracking back to
//   mate one at its first op, registers at 0.2 / 0.1 / 0.
module read_pair_alignment_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [rpac_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rpac_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // op stream
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rpac_pkg::rpac_in_t                in_data_i,
  // pair results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rpac_pkg::rpac_out_t               out_data_o
);
  import rpac_pkg::*;

  rpac_cfg_t  cfg;
  rpac_item_t item;
  logic       item_valid;
  logic       item_take;

  // The user must write config registers only while the pipe is empty, so both
  // stages see a stable copy; the block itself does not enforce this.
  rpac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Front register: one op per transfer, clip and mismatch limits
  // precomputed. It stalls only when the op in it would finish a pair
  // while the result register is still full and stalled.
  rpac_ingress u_ingress (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // Per-mate accumulation, status decision and the pair result register.
  rpac_classifier u_class (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
